/* design/psg_pkg.sv */
// Package for the tone and noise sound generator: beat types, constants and
// the attenuation ROM. No dependencies.
package psg_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_beat_type;

   typedef struct packed {
      logic [12:0] tone0_level;
      logic [12:0] tone1_level;
      logic [12:0] tone2_level;
      logic [12:0] noise_level;
   } rsp_beat_type;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic CSR_STEP_SCALE = 1'b0;
   localparam logic CSR_ENABLE     = 1'b1;

   localparam logic [16:0] CNT_MASK    = 17'h1FFFF;
   localparam logic [16:0] NOISE_SEED  = 17'h04000;
   localparam logic [16:0] FB_WHITE    = 17'h12000;
   localparam logic [16:0] FB_PERIODIC = 17'h08000;

   localparam int QUEUE_DEPTH = 2;

   function automatic logic [12:0] atten_rom(input logic [3:0] code);
      logic [12:0] v;
      unique case (code)
         4'd0:  v = 13'd6826;
         4'd1:  v = 13'd5422;
         4'd2:  v = 13'd4307;
         4'd3:  v = 13'd3421;
         4'd4:  v = 13'd2717;
         4'd5:  v = 13'd2158;
         4'd6:  v = 13'd1714;
         4'd7:  v = 13'd1362;
         4'd8:  v = 13'd1081;
         4'd9:  v = 13'd859;
         4'd10: v = 13'd682;
         4'd11: v = 13'd542;
         4'd12: v = 13'd430;
         4'd13: v = 13'd342;
         4'd14: v = 13'd271;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

endpackage

/* design/psg_queue.sv */
// Short queue of request beats between front and back parts.
// Depends on psg_pkg.
module psg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psg_pkg::req_beat_type push_data,
   output logic                  full,
   input  logic                  pop,
   output psg_pkg::req_beat_type pop_data,
   output logic                  empty
);
   psg_pkg::req_beat_type mem_ff [psg_pkg::QUEUE_DEPTH];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'(psg_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

/* design/psg_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies.
module psg_divider #(
   parameter int STEP_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [23:0]           dividend,
   input  logic [9:0]            divisor,
   output logic                  done,
   output logic [STEP_WIDTH-1:0] quotient
);
   logic [23:0] quo_ff, quo_in;
   logic [10:0] rem_ff, rem_in;
   logic [9:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [10:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial  = {rem_ff[9:0], quo_ff[23]};
      if (start) begin
         quo_in = dividend; rem_in = 11'd0;
         dvs_in = (divisor == 10'd0) ? 10'd1 : divisor;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = STEP_WIDTH'({8'd0, quo_ff});
endmodule

/* design/psg_engine.sv */
// Back part: register writes, step computation and per-sample channel update.
// Depends on psg_pkg and psg_divider.
module psg_engine #(
   parameter int STEP_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [23:0]           step_scale,
   input  logic [3:0]            enable_mask,
   input  logic                  in_valid,
   input  psg_pkg::req_beat_type in_beat,
   output logic                  in_take,
   output logic                  out_empty,
   output psg_pkg::rsp_beat_type out_beat,
   input  logic                  out_pop
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  lidx_ff, lidx_in;
   logic [9:0]  regs_ff [8];
   logic [9:0]  regs_in [8];
   logic [12:0] vol_ff [4];
   logic [12:0] vol_in [4];
   logic [STEP_WIDTH-1:0] step_ff [4];
   logic [STEP_WIDTH-1:0] step_in [4];
   logic [16:0] cnt_ff [4];
   logic [16:0] cnt_in [4];
   logic [16:0] shf_ff, shf_in, fb_ff, fb_in;
   logic [1:0]  dch_ff, dch_in;
   logic        ov_ff, ov_in;
   psg_pkg::rsp_beat_type ob_ff, ob_in;
   logic        div_start, div_done;
   logic [9:0]  div_period;
   logic [STEP_WIDTH-1:0] div_q;
   logic [7:0]  d;
   logic [2:0]  idx;
   logic [12:0] lvl [4];
   logic [16:0] sum;
   logic        can_take;

   psg_divider #(.STEP_WIDTH(STEP_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(step_scale),
      .divisor(div_period), .done(div_done), .quotient(div_q)
   );

   assign d = in_beat.data_byte;
   assign can_take = (state_ff == ST_IDLE) && in_valid && (!ov_ff || out_pop ||
                     in_beat.req_type == psg_pkg::REQ_WRITE);
   assign in_take = can_take;
   assign out_empty = !ov_ff;
   assign out_beat = ob_ff;

   always_comb begin
      state_in = state_ff; lidx_in = lidx_ff; regs_in = regs_ff; vol_in = vol_ff;
      step_in = step_ff; cnt_in = cnt_ff; shf_in = shf_ff; fb_in = fb_ff;
      dch_in = dch_ff; ob_in = ob_ff; ov_in = ov_ff && !out_pop;
      div_start = 1'b0; div_period = regs_ff[{dch_ff, 1'b0}];
      idx = d[6:4]; sum = 17'd0;
      for (int c = 0; c < 4; c++) lvl[c] = 13'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (can_take && in_beat.req_type == psg_pkg::REQ_WRITE) begin
               if (d[7]) begin
                  lidx_in = idx;
                  regs_in[idx] = {regs_ff[idx][9:4], d[3:0]};
                  if (idx[0]) begin
                     vol_in[idx[2:1]] = psg_pkg::atten_rom(d[3:0]);
                  end else if (idx[2:1] != 2'd3) begin
                     dch_in = idx[2:1]; state_in = ST_DIV;
                  end else begin
                     shf_in = psg_pkg::NOISE_SEED;
                     unique case (d[1:0])
                        2'd0: step_in[3] = STEP_WIDTH'(step_scale >> 5);
                        2'd1: step_in[3] = STEP_WIDTH'(step_scale >> 6);
                        2'd2: step_in[3] = STEP_WIDTH'(step_scale >> 7);
                        default: step_in[3] = step_ff[2] >> 1;
                     endcase
                     fb_in = d[2] ? psg_pkg::FB_WHITE : psg_pkg::FB_PERIODIC;
                  end
               end else if (!lidx_ff[0] && lidx_ff[2:1] != 2'd3) begin
                  regs_in[lidx_ff] = {d[5:0], regs_ff[lidx_ff][3:0]};
                  dch_in = lidx_ff[2:1]; state_in = ST_DIV;
               end
            end else if (can_take) begin
               for (int c = 0; c < 3; c++) begin
                  if (enable_mask[c]) begin
                     sum = cnt_ff[c] + step_ff[c][16:0];
                     if (vol_ff[c] != 13'd0 && step_ff[c] >= STEP_WIDTH'(17'h10000)) begin
                        lvl[c] = vol_ff[c];
                     end else begin
                        cnt_in[c] = sum;
                        if (vol_ff[c] != 13'd0 && sum[16]) lvl[c] = vol_ff[c];
                     end
                  end
               end
               if (enable_mask[3]) begin
                  sum = cnt_ff[3] + step_ff[3][16:0];
                  if (vol_ff[3] != 13'd0) begin
                     if (shf_ff[0]) begin
                        lvl[3] = vol_ff[3];
                        if (sum[16]) begin
                           sum[16] = 1'b0;
                           shf_in = (shf_ff ^ fb_ff) >> 1;
                        end
                     end else if (sum[16]) begin
                        sum[16] = 1'b0;
                        shf_in = shf_ff >> 1;
                     end
                  end
                  cnt_in[3] = sum;
               end
               ob_in = '{lvl[0], lvl[1], lvl[2], lvl[3]};
               ov_in = 1'b1;
            end
         end
         ST_DIV: begin
            div_start = 1'b1; state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               step_in[dch_ff] = div_q;
               if (dch_ff == 2'd2 && regs_ff[6][1:0] == 2'd3) step_in[3] = div_q >> 1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; lidx_ff <= 3'd0; ov_ff <= 1'b0;
         shf_ff <= 17'd0; fb_ff <= 17'd0; dch_ff <= 2'd0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 10'd0;
         for (int i = 0; i < 4; i++) begin
            vol_ff[i] <= 13'd0; step_ff[i] <= '0; cnt_ff[i] <= 17'd0;
         end
      end else begin
         state_ff <= state_in; lidx_ff <= lidx_in; ov_ff <= ov_in;
         shf_ff <= shf_in; fb_ff <= fb_in; dch_ff <= dch_in;
         regs_ff <= regs_in; vol_ff <= vol_in; step_ff <= step_in; cnt_ff <= cnt_in;
      end
      ob_ff <= ob_in;
   end
endmodule

/* design/psg_tone_noise_generator_top.sv */
// Top level of the tone and noise generator: front queue plus back engine.
// Depends on psg_pkg, psg_queue, psg_engine.
//
//  channel  ports                       beat
//  request  req_push/req_full/req_beat  req_beat_type
//  result   rsp_pop/rsp_empty/rsp_beat  rsp_beat_type
//  config   csr_we/csr_index/csr_wdata  24-bit write
//
// A tone period write waits in the engine for the bit-serial 24-bit divider;
// ticks and other writes need no division, and no beat is taken while it runs.
// Reset is synchronous; a waiting result holds until popped and later ticks
// stall in the queue.
module psg_tone_noise_generator_top #(
   parameter int STEP_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  psg_pkg::req_beat_type req_beat,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output psg_pkg::rsp_beat_type rsp_beat,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [23:0]           csr_wdata
);
   logic [23:0] scale_ff;
   logic [3:0]  mask_ff;
   logic        q_empty, take;
   psg_pkg::req_beat_type q_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 24'd0; mask_ff <= 4'hF;
      end else if (csr_we) begin
         if (csr_index == psg_pkg::CSR_STEP_SCALE) scale_ff <= csr_wdata;
         else mask_ff <= csr_wdata[3:0];
      end
   end

   psg_queue u_queue (
      .clock(clock), .reset(reset), .push(req_push), .push_data(req_beat),
      .full(req_full), .pop(take), .pop_data(q_beat), .empty(q_empty)
   );

   psg_engine #(.STEP_WIDTH(STEP_WIDTH)) u_engine (
      .clock(clock), .reset(reset), .step_scale(scale_ff), .enable_mask(mask_ff),
      .in_valid(!q_empty), .in_beat(q_beat), .in_take(take),
      .out_empty(rsp_empty), .out_beat(rsp_beat), .out_pop(rsp_pop)
   );
endmodule
